FILE: rtl/iis_pkg.sv
// ---------------------------------------------------------------------------
// Integral image stream package
// Shared constants, register codes and types for the summed-area table core.
// ---------------------------------------------------------------------------
`default_nettype none

package iis_pkg;

   // Fixed field widths of the stream and configuration interfaces.
   localparam int PIXEL_W     = 16;
   localparam int SUM_W       = 36;
   localparam int RSP_TDATA_W = 40;
   localparam int CFG_W       = 11;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // Default parameter values.
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_PIXEL_BITS = 16;
   localparam int FIFO_DEPTH     = 4;

   // Reset value of both image dimension registers.
   localparam int DIM_RESET = 1024;

   // Register codes, taken from address bit 2.
   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   // Per-pixel classification handed from the front end to the back end.
   typedef struct packed {
      logic first_row;
      logic frame_end;
   } iis_flags_type;

endpackage

`default_nettype wire

FILE: rtl/integral_image_stream_core.sv
// ---------------------------------------------------------------------------
// Integral image stream core
// Streaming summed-area table over a raster-order grayscale pixel stream.
// ---------------------------------------------------------------------------
// One pixel is accepted per clock and one result leaves per clock when both
// sides keep streaming. Each result is the sum of all pixels at or above the
// current row and at or left of the current column; rsp_tlast marks the
// frame's last pixel. The front end keeps the row and column counters and the
// running row sum, a four-entry queue decouples it from the back end, and the
// back end holds a line store of MAX_WIDTH entries of 36 bits (one read and
// one write per cycle) with the previous row's results. Writing image_width or
// image_height restarts the frame; values of zero count as one and values
// above the maximum saturate. Only the low PIXEL_BITS bits of a pixel count.
// ---------------------------------------------------------------------------
`default_nettype none

module integral_image_stream_core
   import iis_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Pixel stream; tdata bits: pixel[15:0]
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [PIXEL_W-1:0]     req_tdata,
   // Result stream; tdata bits: area_sum[35:0], zero fill[39:36]; tlast: frame_end
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,
   output      logic                   rsp_tlast,
   // Configuration port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [CSR_DATA_W-1:0]  csr_prdata,
   output      logic                   csr_pready
);

   localparam int PIX_USE = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int RSUM_W  = PIX_USE + COL_W;
   localparam int ENTRY_W = RSUM_W + COL_W + $bits(iis_flags_type);

   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               queue_full;
   logic               pop_valid;
   logic [ENTRY_W-1:0] pop_data;
   logic               pop;

   assign csr_pready = 1'b1;

   iis_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIX_USE),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W),
      .RSUM_W     (RSUM_W),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .push        (push),
      .push_data   (push_data),
      .queue_full  (queue_full)
   );

   iis_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop)
   );

   iis_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W),
      .RSUM_W    (RSUM_W),
      .ENTRY_W   (ENTRY_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/iis_front.sv
// ---------------------------------------------------------------------------
// Integral image front end
// Holds the dimension registers, accepts pixels, tracks row and column and
// forms the running row sum that is queued for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module iis_front
   import iis_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS,
   parameter int COL_W      = $clog2(MAX_WIDTH),
   parameter int ROW_W      = $clog2(MAX_HEIGHT),
   parameter int RSUM_W     = PIXEL_BITS + COL_W,
   parameter int ENTRY_W    = RSUM_W + COL_W + $bits(iis_flags_type)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Pixel stream
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [PIXEL_W-1:0]    req_tdata,
   // Configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   // Queue side
   output      logic                  push,
   output      logic [ENTRY_W-1:0]    push_data,
   input  wire logic                  queue_full
);

   localparam int PIX_USE = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
   localparam int W_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS  = $clog2(MAX_HEIGHT + 1);
   localparam int DW_W    = (CFG_W > W_BITS) ? CFG_W : W_BITS;
   localparam int DH_W    = (CFG_W > H_BITS) ? CFG_W : H_BITS;
   localparam int WLAST_RESET = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH - 1 : DIM_RESET - 1;
   localparam int HLAST_RESET = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT - 1 : DIM_RESET - 1;

   logic [CFG_W-1:0]  width_raw_ff, width_raw_in;
   logic [CFG_W-1:0]  height_raw_ff, height_raw_in;
   logic [COL_W-1:0]  wlast_ff, wlast_in;
   logic [ROW_W-1:0]  hlast_ff, hlast_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [RSUM_W-1:0] rsum_ff, rsum_in;

   logic              csr_write;
   logic [CFG_W-1:0]  wdat;
   logic [COL_W-1:0]  wlast_new;
   logic [ROW_W-1:0]  hlast_new;
   logic              accept;
   logic              last_col;
   logic              last_row;
   logic [RSUM_W-1:0] rsum_new;
   iis_flags_type     flags;

   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign wdat      = csr_pwdata[CFG_W-1:0];

   // Clamp the written dimension to 1..MAX and keep it as the last index.
   always_comb begin
      if (wdat == '0) begin
         wlast_new = '0;
      end else if (DW_W'(wdat) > DW_W'(MAX_WIDTH)) begin
         wlast_new = COL_W'(MAX_WIDTH - 1);
      end else begin
         wlast_new = COL_W'(wdat - CFG_W'(1));
      end
      if (wdat == '0) begin
         hlast_new = '0;
      end else if (DH_W'(wdat) > DH_W'(MAX_HEIGHT)) begin
         hlast_new = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         hlast_new = ROW_W'(wdat - CFG_W'(1));
      end
   end

   assign req_tready = ~queue_full;
   assign accept     = req_tvalid & req_tready;
   assign last_col   = (col_ff == wlast_ff);
   assign last_row   = (row_ff == hlast_ff);
   assign rsum_new   = rsum_ff + RSUM_W'(req_tdata[PIX_USE-1:0]);

   assign flags.first_row = (row_ff == '0);
   assign flags.frame_end = last_col & last_row;
   assign push            = accept;
   assign push_data       = {rsum_new, col_ff, flags};

   always_comb begin
      width_raw_in  = width_raw_ff;
      height_raw_in = height_raw_ff;
      wlast_in      = wlast_ff;
      hlast_in      = hlast_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      rsum_in       = rsum_ff;
      if (csr_write) begin
         // Any register write restarts the frame.
         case (csr_paddr[2:2])
            REG_WIDTH: begin
               width_raw_in = wdat;
               wlast_in     = wlast_new;
            end
            REG_HEIGHT: begin
               height_raw_in = wdat;
               hlast_in      = hlast_new;
            end
            default: begin
               width_raw_in = width_raw_ff;
            end
         endcase
         col_in  = '0;
         row_in  = '0;
         rsum_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in  = '0;
            rsum_in = '0;
            row_in  = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in  = col_ff + COL_W'(1);
            rsum_in = rsum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= CFG_W'(DIM_RESET);
         height_raw_ff <= CFG_W'(DIM_RESET);
         wlast_ff      <= COL_W'(WLAST_RESET);
         hlast_ff      <= ROW_W'(HLAST_RESET);
         col_ff        <= '0;
         row_ff        <= '0;
         rsum_ff       <= '0;
      end else begin
         width_raw_ff  <= width_raw_in;
         height_raw_ff <= height_raw_in;
         wlast_ff      <= wlast_in;
         hlast_ff      <= hlast_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         rsum_ff       <= rsum_in;
      end
   end

   always_comb begin
      case (csr_paddr[2:2])
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_raw_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_raw_ff);
         default:    csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/iis_queue.sv
// ---------------------------------------------------------------------------
// Integral image queue
// Short first-in first-out buffer between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module iis_queue
   import iis_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int DEPTH  = FIFO_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output      logic              full,
   output      logic              pop_valid,
   output      logic [DATA_W-1:0] pop_data,
   input  wire logic              pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slots [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slots[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/iis_back.sv
// ---------------------------------------------------------------------------
// Integral image back end
// Reads the previous row's result from the line store, adds the row sum,
// writes the new result back and presents it on the result stream.
// ---------------------------------------------------------------------------
`default_nettype none

module iis_back
   import iis_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH),
   parameter int RSUM_W    = DEF_PIXEL_BITS + COL_W,
   parameter int ENTRY_W   = RSUM_W + COL_W + $bits(iis_flags_type)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   input  wire logic [ENTRY_W-1:0]     pop_data,
   output      logic                   pop,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,
   output      logic                   rsp_tlast
);

   localparam int FLAGS_W = $bits(iis_flags_type);

   logic [SUM_W-1:0]  line_mem [MAX_WIDTH];

   logic [RSUM_W-1:0] a_rsum;
   logic [COL_W-1:0]  a_col;
   iis_flags_type     a_flags;

   logic              b_valid_ff, b_valid_in;
   logic [RSUM_W-1:0] b_rsum_ff;
   logic [COL_W-1:0]  b_col_ff;
   iis_flags_type     b_flags_ff;
   logic [SUM_W-1:0]  rd_ff;
   logic [SUM_W-1:0]  fwd_ff;
   logic              use_fwd_ff;

   logic              out_valid_ff, out_valid_in;
   logic [SUM_W-1:0]  out_sum_ff;
   logic              out_last_ff;

   logic [SUM_W-1:0]  above;
   logic [SUM_W-1:0]  sum_b;
   logic              out_adv;
   logic              b_move;

   assign a_rsum  = pop_data[ENTRY_W-1 -: RSUM_W];
   assign a_col   = pop_data[FLAGS_W +: COL_W];
   assign a_flags = iis_flags_type'(pop_data[FLAGS_W-1:0]);

   // The entry for this column may be written at the same edge as it is read
   // (an image one pixel wide); the read then takes the result being written.
   assign above  = use_fwd_ff ? fwd_ff : rd_ff;
   assign sum_b  = SUM_W'(b_rsum_ff) + (b_flags_ff.first_row ? '0 : above);

   assign out_adv = ~out_valid_ff | rsp_tready;
   assign b_move  = b_valid_ff & out_adv;
   assign pop     = pop_valid & (~b_valid_ff | b_move);

   assign b_valid_in   = pop | (b_valid_ff & ~b_move);
   assign out_valid_in = b_move | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_rsum_ff  <= a_rsum;
         b_col_ff   <= a_col;
         b_flags_ff <= a_flags;
         rd_ff      <= line_mem[a_col];
         fwd_ff     <= sum_b;
         use_fwd_ff <= b_move & (b_col_ff == a_col);
      end
      if (b_move) begin
         line_mem[b_col_ff] <= sum_b;
         out_sum_ff         <= sum_b;
         out_last_ff        <= b_flags_ff.frame_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - SUM_W)'(0), out_sum_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

FILE: bench/iis_area_checker.sv
// ---------------------------------------------------------------------------
// Summed-area result checker
// Watches the pixel, result and configuration channels of the integral image
// core, predicts every summed-area result and compares it with the block's.
// ---------------------------------------------------------------------------

module iis_area_checker
   import iis_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // tdata bits: pixel[15:0]
   input  wire logic [PIXEL_W-1:0]     req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // tdata bits: area_sum[35:0], zero fill[39:36]; tlast: frame_end
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   rsp_tlast,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic                   csr_pready,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output int                          mismatch_count,
   output int                          pending_count
);

   localparam logic [PIXEL_W-1:0] PIXEL_MASK =
      (PIXEL_BITS >= PIXEL_W) ? {PIXEL_W{1'b1}} : PIXEL_W'((1 << PIXEL_BITS) - 1);

   typedef struct packed {
      logic [SUM_W-1:0] area_sum;
      logic             frame_end;
   } area_result_type;

   area_result_type  expected_sums[$];
   area_result_type  oldest;
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic [SUM_W-1:0] row_sum;
   logic [SUM_W-1:0] line_sums [MAX_WIDTH];
   int unsigned      col;
   int unsigned      row;
   int               errors;

   function automatic int unsigned dim_limit(input logic [CFG_W-1:0] raw,
                                             input int unsigned ceiling);
      if (raw == '0) return 1;
      if (raw > ceiling) return ceiling;
      return raw;
   endfunction

   task automatic restart_frame();
      row_sum = '0;
      col     = 0;
      row     = 0;
   endtask

   task automatic predict_area(input logic [PIXEL_W-1:0] pixel);
      int unsigned      w;
      int unsigned      h;
      logic [SUM_W-1:0] above;
      logic [SUM_W-1:0] total;
      area_result_type  item;
      w = dim_limit(width_reg, MAX_WIDTH);
      h = dim_limit(height_reg, MAX_HEIGHT);
      if (col >= w || row >= h) restart_frame();
      row_sum = row_sum + SUM_W'(pixel & PIXEL_MASK);
      // The first row of a frame has nothing above it; the line store is
      // only read for rows that the current frame has already written.
      above = '0;
      if (row != 0 && col < MAX_WIDTH) above = line_sums[col];
      total = row_sum + above;
      if (col < MAX_WIDTH) line_sums[col] = total;
      item.area_sum  = total;
      item.frame_end = (col + 1 >= w) && (row + 1 >= h);
      expected_sums.push_back(item);
      if (col + 1 >= w) begin
         col     = 0;
         row_sum = '0;
         row     = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = CFG_W'(DIM_RESET);
         height_reg = CFG_W'(DIM_RESET);
         restart_frame();
         expected_sums.delete();
         errors = 0;
      end else begin
         // A register write takes effect at once and restarts the frame.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_WIDTH) width_reg = csr_pwdata[CFG_W-1:0];
            else height_reg = csr_pwdata[CFG_W-1:0];
            restart_frame();
         end
         if (req_tvalid && req_tready) predict_area(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sums.size() == 0) begin
               errors++;
               $display("%0t: result transaction with nothing expected, got sum %0d last %0b",
                        $time, rsp_tdata[SUM_W-1:0], rsp_tlast);
            end else begin
               oldest = expected_sums.pop_front();
               if (rsp_tdata[SUM_W-1:0] !== oldest.area_sum) begin
                  errors++;
                  $display("%0t: area_sum mismatch, expected %0d, got %0d",
                           $time, oldest.area_sum, rsp_tdata[SUM_W-1:0]);
               end
               if (rsp_tdata[RSP_TDATA_W-1:SUM_W] !== '0) begin
                  errors++;
                  $display("%0t: tdata fill mismatch, expected 0, got %0h",
                           $time, rsp_tdata[RSP_TDATA_W-1:SUM_W]);
               end
               if (rsp_tlast !== oldest.frame_end) begin
                  errors++;
                  $display("%0t: frame_end mismatch, expected %0b, got %0b",
                           $time, oldest.frame_end, rsp_tlast);
               end
            end
         end
      end
      pending_count  <= expected_sums.size();
      mismatch_count <= errors;
   end

endmodule

FILE: bench/tb_integral_image_stream_core.sv
// ---------------------------------------------------------------------------
// Integral image stream core testbench
// Streams directed and random pixel frames at many image sizes through the
// core under random stalls on both sides; a checker predicts every result.
// ---------------------------------------------------------------------------

module tb_integral_image_stream_core;
   import iis_pkg::*;

   localparam int RANDOM_ITEMS = 200;
   localparam int HOLD_AFTER   = 200;
   localparam int HOLD_CYCLES  = 80;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int                     mismatch_count;
   int                     pending_count;
   int                     pixels_accepted;
   logic [PIXEL_W-1:0]     pixel_plan[$];
   logic [CFG_W-1:0]       width_raw;
   logic [CFG_W-1:0]       height_raw;

   integral_image_stream_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   iis_area_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("integral_image_stream_core verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) pixels_accepted <= 0;
      else if (req_tvalid && req_tready) pixels_accepted <= pixels_accepted + 1;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int unsigned effective_dim(input logic [CFG_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > DIM_RESET) return DIM_RESET;
      return raw;
   endfunction

   function automatic logic [PIXEL_W-1:0] random_pixel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return PIXEL_W'($urandom_range(0, 65535));
   endfunction

   // Result side: random ready pattern, plus one long hold-off once the
   // stream is well under way so that the core backs up into its input.
   initial begin
      int off;
      int burst;
      bit held_off;
      held_off = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && pixels_accepted >= HOLD_AFTER) begin
            held_off = 1'b1;
            off = HOLD_CYCLES;
         end else begin
            off = idle_cycles();
         end
         if (off > 0) begin
            rsp_tready <= 1'b0;
            repeat (off) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         burst = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(40, 150);
         repeat (burst) @(posedge clock);
      end
   end

   task automatic push_pixel(input logic [PIXEL_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic stream_plan(input bit steady);
      int gap;
      while (pixel_plan.size() != 0) begin
         push_pixel(pixel_plan.pop_front());
         gap = steady ? 0 : idle_cycles();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] reg_code, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_code, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // Random upper bits ride along with every write; only the low bits count.
   task automatic configure(input bit set_width, input logic [CFG_W-1:0] w,
                            input bit set_height, input logic [CFG_W-1:0] h);
      logic [CSR_DATA_W-1:0] word;
      if (set_width) begin
         word = $urandom();
         word[CFG_W-1:0] = w;
         width_raw = w;
         write_reg(REG_WIDTH, word);
      end
      if (set_height) begin
         word = $urandom();
         word[CFG_W-1:0] = h;
         height_raw = h;
         write_reg(REG_HEIGHT, word);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic fill_random(input int count);
      repeat (count) pixel_plan.push_back(random_pixel());
   endtask

   initial begin
      int               random_items;
      int               count;
      int               r;
      int unsigned      frame_pixels;
      bit               set_w;
      bit               set_h;
      logic [CFG_W-1:0] w;
      logic [CFG_W-1:0] h;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      width_raw   = CFG_W'(DIM_RESET);
      height_raw  = CFG_W'(DIM_RESET);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset dimensions: the start of the top row of a full-size frame with extreme pixels.
      pixel_plan = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001};
      stream_plan(1'b0);
      wait_drained();

      // Zero width and height count as one: every pixel is a whole frame.
      configure(1'b1, '0, 1'b1, '0);
      pixel_plan = '{16'hFFFF, 16'h1234, 16'hFFFF};
      stream_plan(1'b1);
      wait_drained();

      // A 3x2 frame, then the first two pixels of the next frame.
      configure(1'b1, 11'd3, 1'b1, 11'd2);
      pixel_plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'h0002, 16'h8000};
      stream_plan(1'b0);
      wait_drained();

      // A register write in the middle of a frame restarts it.
      configure(1'b1, 11'd4, 1'b1, 11'd4);
      pixel_plan = '{16'h0010, 16'h0020, 16'h0040, 16'h0080, 16'h0100};
      stream_plan(1'b0);
      wait_drained();
      configure(1'b0, '0, 1'b1, 11'd3);
      pixel_plan = '{16'h7FFF, 16'hC000, 16'h0F0F, 16'hF0F0};
      stream_plan(1'b0);
      wait_drained();

      // Full-width rows, saturated or exactly at the maximum, one row per frame.
      w = ($urandom_range(0, 1) != 0) ? CFG_W'(DIM_RESET) : CFG_W'($urandom_range(1025, 2047));
      configure(1'b1, w, 1'b1, 11'd1);
      fill_random(DIM_RESET + $urandom_range(8, 40));
      stream_plan($urandom_range(0, 3) == 0);
      wait_drained();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 6) w = '0;
         else if (r < 10) w = CFG_W'($urandom_range(1025, 2047));
         else if (r < 14) w = CFG_W'($urandom_range(40, 1024));
         else w = CFG_W'($urandom_range(1, 12));
         r = $urandom_range(0, 99);
         if (r < 6) h = '0;
         else if (r < 10) h = CFG_W'($urandom_range(1024, 2047));
         else h = CFG_W'($urandom_range(1, 8));
         r = $urandom_range(0, 9);
         set_w = (r != 0);
         set_h = (r != 1);
         configure(set_w, w, set_h, h);

         frame_pixels = effective_dim(width_raw) * effective_dim(height_raw);
         if (frame_pixels <= 60)
            count = frame_pixels * $urandom_range(1, 3) + $urandom_range(0, 4);
         else
            count = $urandom_range(20, 80);
         fill_random(count);
         stream_plan($urandom_range(0, 3) == 0);
         wait_drained();
         random_items += count;
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("integral_image_stream_core verification clean");
      end else begin
         $display("integral_image_stream_core verification failed");
      end
      $finish;
   end

endmodule

FILE: integral_image_stream_core.f
rtl/iis_pkg.sv
rtl/iis_front.sv
rtl/iis_queue.sv
rtl/iis_back.sv
rtl/integral_image_stream_core.sv
bench/iis_area_checker.sv
bench/tb_integral_image_stream_core.sv
